[design/canonical_huffman_code_assign_defines.svh]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_CODE_ASSIGN_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODE_ASSIGN_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define CHCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold in every cycle out of reset.
`define CHCA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`else

`define CHCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CHCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define CHCA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`endif

`endif

[design/chca_pkg.sv]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: package
// Widths, status codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package chca_pkg;

    localparam int MAX_CODE_BITS = 15;
    localparam int ALPHABET_SIZE = 512;

    localparam int SYM_W   = $clog2(ALPHABET_SIZE);      // symbol index
    localparam int CNT_W   = $clog2(ALPHABET_SIZE + 1);  // symbol count, up to the size
    localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);  // stored code length
    localparam int NUM_LEN = 1 << LEN_W;                 // entries per length table
    localparam int CODE_W  = 15;                         // stored code
    localparam int FIRST_W = 16;                         // first code, with wrap bit
    localparam int LCNT_W  = 10;                         // count per length
    localparam int LEN_IN_W = 5;                         // incoming length field
    localparam int STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_CODE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_BUILD,
        S_SINGLE,
        S_COUNT,
        S_PREFIX,
        S_ASGN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // a length request is accepted this cycle
        logic lookup;   // a lookup request is accepted this cycle
        logic reply;    // lookup response cycle
        logic build;    // clear the per-length counts and pass counters
        logic single;   // one-length set: force symbol 0 to code 1 of length 1
        logic count;    // counting pass over the stored lengths
        logic prefix;   // one step of the first-code recurrence
        logic asg;      // code assignment pass over the stored lengths
        logic done;     // build response cycle
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_done;    // symbol pass has issued and retired every read
        logic prefix_last;  // current prefix step is for the longest length
        logic too_long;     // the set held a length above the maximum
        logic single_set;   // the set holds exactly one length
    } t_stat;

endpackage

[design/chca_ram.sv]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/chca_dpath.sv]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: datapath
// Length and code stores, per-length counts, first codes and pass counters.
// ----------------------------------------------------------------------------
`include "canonical_huffman_code_assign_defines.svh"

module chca_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  chca_pkg::t_cmd                  i_cmd,
    output chca_pkg::t_stat                 o_stat,
    input  logic [chca_pkg::LEN_IN_W-1:0]   i_code_len_in,
    input  logic                            i_last_length,
    input  logic [chca_pkg::SYM_W-1:0]      i_lookup_symbol,
    output logic [chca_pkg::STAT_W-1:0]     o_status,
    output logic [chca_pkg::CODE_W-1:0]     o_code_value,
    output logic [chca_pkg::LEN_W-1:0]      o_code_bits
);

    import chca_pkg::*;

    // Set bookkeeping.
    logic [CNT_W-1:0]   r_loaded_cnt, n_loaded_cnt;
    logic               r_too_long, n_too_long;
    logic               r_set_open, n_set_open;
    logic               r_table_valid, n_table_valid;
    logic               r_hit, n_hit;

    // Build state.
    logic [LCNT_W-1:0]  r_count [NUM_LEN];
    logic [LCNT_W-1:0]  n_count [NUM_LEN];
    logic [FIRST_W-1:0] r_first [NUM_LEN];
    logic [FIRST_W-1:0] n_first [NUM_LEN];
    logic [FIRST_W-1:0] r_code_acc, n_code_acc;
    logic [LEN_W-1:0]   r_bit, n_bit;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pipe_vld, n_pipe_vld;
    logic [SYM_W-1:0]   r_pipe_idx, n_pipe_idx;

    // Store ports.
    logic               len_we;
    logic [SYM_W-1:0]   len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic [SYM_W-1:0]   len_raddr;
    logic [LEN_W-1:0]   len_rdata;
    logic               code_we;
    logic [SYM_W-1:0]   code_waddr;
    logic [CODE_W-1:0]  code_wdata;
    logic [CODE_W-1:0]  code_rdata;

    // Load decode.
    logic               new_set;
    logic [CNT_W-1:0]   cnt_base;
    logic               room;
    logic               len_too_long;
    logic               issue;
    logic [LEN_W-1:0]   cnt_ridx;
    logic [LCNT_W-1:0]  cnt_rd;
    logic [FIRST_W-1:0] prefix_sum;

    assign new_set      = !r_set_open;
    assign cnt_base     = new_set ? '0 : r_loaded_cnt;
    assign room         = cnt_base < CNT_W'(ALPHABET_SIZE);
    assign len_too_long = i_code_len_in > LEN_IN_W'(MAX_CODE_BITS);
    assign issue        = r_idx < r_loaded_cnt;

    // The count table has one read address: the stored length during the
    // counting pass, the next shorter length during the prefix steps.
    assign cnt_ridx   = i_cmd.prefix ? (r_bit - LEN_W'(1)) : len_rdata;
    assign cnt_rd     = r_count[cnt_ridx];
    assign prefix_sum = r_code_acc + FIRST_W'(cnt_rd);

    always_comb begin
        len_we    = 1'b0;
        len_waddr = cnt_base[SYM_W-1:0];
        len_wdata = i_code_len_in[LEN_W-1:0];
        if (i_cmd.load) begin
            len_we = room && !len_too_long;
        end else if (i_cmd.single) begin
            len_we    = 1'b1;
            len_waddr = '0;
            len_wdata = LEN_W'(1);
        end
    end

    assign len_raddr = i_cmd.lookup ? i_lookup_symbol : r_idx[SYM_W-1:0];

    always_comb begin
        code_we    = 1'b0;
        code_waddr = r_pipe_idx;
        code_wdata = r_first[len_rdata][CODE_W-1:0];
        if (i_cmd.single) begin
            code_we    = 1'b1;
            code_waddr = '0;
            code_wdata = CODE_W'(1);
        end else if (i_cmd.asg && r_pipe_vld && len_rdata != '0) begin
            code_we = 1'b1;
        end
    end

    always_comb begin
        n_loaded_cnt  = r_loaded_cnt;
        n_too_long    = r_too_long;
        n_set_open    = r_set_open;
        n_table_valid = r_table_valid;
        n_hit         = r_hit;
        n_count       = r_count;
        n_first       = r_first;
        n_code_acc    = r_code_acc;
        n_bit         = r_bit;
        n_idx         = r_idx;
        n_pipe_vld    = 1'b0;
        n_pipe_idx    = r_idx[SYM_W-1:0];

        if (i_cmd.load) begin
            n_set_open = !i_last_length;
            n_too_long = (new_set ? 1'b0 : r_too_long) | (room & len_too_long);
            n_loaded_cnt = room ? (cnt_base + CNT_W'(1)) : cnt_base;
            if (new_set) begin
                n_table_valid = 1'b0;
            end
        end

        if (i_cmd.lookup) begin
            n_hit = r_table_valid && ({1'b0, i_lookup_symbol} < r_loaded_cnt);
        end

        if (i_cmd.build) begin
            for (int i = 0; i < NUM_LEN; i++) begin
                n_count[i] = '0;
            end
            n_code_acc = '0;
            n_bit      = LEN_W'(1);
            n_idx      = '0;
        end

        if (i_cmd.count || i_cmd.asg) begin
            n_pipe_vld = issue;
            if (issue) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end

        if (i_cmd.count && r_pipe_vld && len_rdata != '0) begin
            n_count[len_rdata] = cnt_rd + LCNT_W'(1);
        end

        if (i_cmd.prefix) begin
            // Next first code is twice the sum of the previous first code and the count of the next shorter length.
            n_code_acc     = {prefix_sum[FIRST_W-2:0], 1'b0};
            n_first[r_bit] = {prefix_sum[FIRST_W-2:0], 1'b0};
            n_bit          = r_bit + LEN_W'(1);
            n_idx          = '0;
        end

        if (i_cmd.asg && r_pipe_vld && len_rdata != '0) begin
            n_first[len_rdata] = r_first[len_rdata] + FIRST_W'(1);
        end

        if (i_cmd.done) begin
            n_table_valid = !r_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_cnt  <= '0;
            r_too_long    <= 1'b0;
            r_set_open    <= 1'b0;
            r_table_valid <= 1'b0;
            r_pipe_vld    <= 1'b0;
        end else begin
            r_loaded_cnt  <= n_loaded_cnt;
            r_too_long    <= n_too_long;
            r_set_open    <= n_set_open;
            r_table_valid <= n_table_valid;
            r_pipe_vld    <= n_pipe_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_count    <= n_count;
        r_first    <= n_first;
        r_code_acc <= n_code_acc;
        r_bit      <= n_bit;
        r_idx      <= n_idx;
        r_pipe_idx <= n_pipe_idx;
    end

    chca_ram #(
        .WIDTH (LEN_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    chca_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (code_waddr),
        .i_wdata (code_wdata),
        .i_raddr (i_lookup_symbol),
        .o_rdata (code_rdata)
    );

    always_comb begin
        o_status     = ST_NO_CODE;
        o_code_value = '0;
        o_code_bits  = '0;
        if (i_cmd.done) begin
            o_status = r_too_long ? ST_TOO_LONG : ST_OK;
        end else if (i_cmd.reply && r_hit && len_rdata != '0) begin
            o_status     = ST_OK;
            o_code_value = code_rdata;
            o_code_bits  = len_rdata;
        end
    end

    assign o_stat.pass_done   = !issue && !r_pipe_vld;
    assign o_stat.prefix_last = r_bit == LEN_W'(MAX_CODE_BITS);
    assign o_stat.too_long    = r_too_long;
    assign o_stat.single_set  = r_loaded_cnt == CNT_W'(1);

    `CHCA_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n,
        r_loaded_cnt <= CNT_W'(ALPHABET_SIZE), "loaded count beyond alphabet")
    `CHCA_ASSERT_IMPLY(a_valid_ok, i_clk, i_rst_n,
        r_table_valid, !r_too_long, "valid table after a too-long length")
    `CHCA_ASSERT_NEXT(a_pipe_idle, i_clk, i_rst_n,
        !(i_cmd.count || i_cmd.asg), !r_pipe_vld, "store read in flight outside a pass")

endmodule

[design/chca_ctrl.sv]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: controller
// Sequences request acceptance, lookup replies and the table build passes.
// ----------------------------------------------------------------------------
`include "canonical_huffman_code_assign_defines.svh"

module chca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_kind,
    input  logic            i_last_length,
    input  chca_pkg::t_stat i_stat,
    output chca_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);

    import chca_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_strobe = 1'b0;
        o_busy   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_kind) begin
                        o_cmd.lookup = 1'b1;
                        n_state      = S_LOOKUP;
                    end else begin
                        o_cmd.load = 1'b1;
                        if (i_last_length) begin
                            n_state = S_BUILD;
                        end
                    end
                end
            end
            S_LOOKUP: begin
                o_cmd.reply = 1'b1;
                o_strobe    = 1'b1;
                n_state     = S_IDLE;
            end
            S_BUILD: begin
                o_cmd.build = 1'b1;
                if (i_stat.too_long) begin
                    n_state = S_DONE;
                end else if (i_stat.single_set) begin
                    n_state = S_SINGLE;
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_SINGLE: begin
                o_cmd.single = 1'b1;
                n_state      = S_DONE;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                if (i_stat.pass_done) begin
                    n_state = S_PREFIX;
                end
            end
            S_PREFIX: begin
                o_cmd.prefix = 1'b1;
                if (i_stat.prefix_last) begin
                    n_state = S_ASGN;
                end
            end
            S_ASGN: begin
                o_cmd.asg = 1'b1;
                if (i_stat.pass_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                o_strobe   = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CHCA_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe, !o_strobe, "result strobe held for two cycles")
    `CHCA_ASSERT_NEXT(a_lookup_reply, i_clk, i_rst_n, i_start && !o_busy && i_kind, o_strobe, "lookup without a reply in the next cycle")

endmodule

[design/canonical_huffman_code_assign.sv]
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: top level
// Loads are taken one per cycle until the final load of a set starts the build;
// they give no response. A lookup's response comes in the cycle after it is
// accepted; no request is taken in that cycle. The build: a clear, two store
// passes over the lengths, 15 prefix steps, the response; a one-length set: a
// clear, a single write, the response; an overlong set: a clear, the response.
// Results cannot be stalled. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
//
// A request is taken on a rising edge with start high and busy low. kind
// selects a length load or a lookup. Loads arrive in symbol order and are
// written straight into the length store at the running symbol count; the
// first load after a closed set starts a new set. A length above the
// maximum is not stored but marks the set as failed.
//
// When a load carries last_length, the controller runs the build:
//   - a clear step zeroes the per-length counts,
//   - a counting pass reads every stored length, one per cycle, and bumps
//     the count for its length,
//   - fifteen steps form the first code of each length from the counts,
//   - an assignment pass reads the lengths again and writes each used
//     symbol's code, bumping the first code of that length as it goes.
// A failed set skips the passes. A set of exactly one length writes
// symbol 0 as code 1 of length 1. The build response carries the status
// only; busy stays high until it has been shown.
//
// Results are shown for exactly one cycle, marked by o_strobe; the
// receiver cannot hold them off. Lookups of a symbol beyond the loaded
// count, of an unused symbol, or while no good table stands, give the
// no-code status. Store entries have no reset; only entries written in the
// current set are ever read.

module canonical_huffman_code_assign (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_kind,
    input  logic [chca_pkg::LEN_IN_W-1:0]   i_code_len_in,
    input  logic                            i_last_length,
    input  logic [chca_pkg::SYM_W-1:0]      i_lookup_symbol,
    output logic                            o_strobe,
    output logic [chca_pkg::STAT_W-1:0]     o_status,
    output logic [chca_pkg::CODE_W-1:0]     o_code_value,
    output logic [chca_pkg::LEN_W-1:0]      o_code_bits
);

    import chca_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    chca_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_kind        (i_kind),
        .i_last_length (i_last_length),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_strobe      (o_strobe)
    );

    chca_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_code_len_in   (i_code_len_in),
        .i_last_length   (i_last_length),
        .i_lookup_symbol (i_lookup_symbol),
        .o_status        (o_status),
        .o_code_value    (o_code_value),
        .o_code_bits     (o_code_bits)
    );

endmodule

[tb/canonical_huffman_code_assign_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Canonical Huffman code assignment: testbench
// Sends sets of code lengths and lookup requests. A scoreboard tracks the
// same length table, rebuilds the canonical codes when a set closes and
// compares every strobed response with the oldest expected response.
// ----------------------------------------------------------------------------

typedef struct {
    chca_pkg::t_status             status;
    logic [chca_pkg::CODE_W-1:0]   code;
    logic [chca_pkg::LEN_W-1:0]    bits;
} t_huff_reply;

typedef int t_len_list[$];

// Tracks the length and code tables, and the responses still owed by the block.
class huffman_scoreboard;
    logic [chca_pkg::LEN_W-1:0]   sym_len   [chca_pkg::ALPHABET_SIZE];
    logic [chca_pkg::CODE_W-1:0]  sym_code  [chca_pkg::ALPHABET_SIZE];
    logic [chca_pkg::LCNT_W-1:0]  len_count [chca_pkg::NUM_LEN];
    logic [chca_pkg::FIRST_W-1:0] next_code [chca_pkg::NUM_LEN];
    int          num_loaded;
    bit          set_too_long;
    bit          set_open;
    bit          table_ok;
    t_huff_reply owed_q[$];
    int          mismatches;
    int          sets_built;
    int          sets_rejected;
    int          lookups;
    int          lookup_hits;

    function new();
        foreach (sym_len[i]) begin
            sym_len[i]  = '0;
            sym_code[i] = '0;
        end
        foreach (len_count[i]) begin
            len_count[i] = '0;
            next_code[i] = '0;
        end
        num_loaded    = 0;
        set_too_long  = 1'b0;
        set_open      = 1'b0;
        table_ok      = 1'b0;
        mismatches    = 0;
        sets_built    = 0;
        sets_rejected = 0;
        lookups       = 0;
        lookup_hits   = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Canonical assignment: count per length, first code per length, then
    // consecutive codes in symbol order. The first-code sum wraps at 16 bits.
    function void build_codes();
        logic [chca_pkg::FIRST_W-1:0] code;
        logic [chca_pkg::LEN_W-1:0]   len;
        if (set_too_long) begin
            table_ok = 1'b0;
            return;
        end
        if (num_loaded == 1) begin
            sym_len[0]  = chca_pkg::LEN_W'(1);
            sym_code[0] = chca_pkg::CODE_W'(1);
            table_ok    = 1'b1;
            return;
        end
        foreach (len_count[i]) begin
            len_count[i] = '0;
            next_code[i] = '0;
        end
        for (int s = 0; s < num_loaded; s++) begin
            len = sym_len[s];
            if (len != 0)
                len_count[len] = len_count[len] + 1'b1;
        end
        code = '0;
        for (int b = 1; b <= chca_pkg::MAX_CODE_BITS; b++) begin
            code = (code + len_count[b-1]) << 1;
            next_code[b] = code;
        end
        for (int s = 0; s < num_loaded; s++) begin
            len = sym_len[s];
            if (len != 0) begin
                sym_code[s]    = next_code[len][chca_pkg::CODE_W-1:0];
                next_code[len] = next_code[len] + 1'b1;
            end
        end
        table_ok = 1'b1;
    endfunction

    // Called for every request the block accepts.
    function void note_request(logic kind, logic [chca_pkg::LEN_IN_W-1:0] len,
                               logic last, logic [chca_pkg::SYM_W-1:0] sym);
        t_huff_reply r;
        r.status = chca_pkg::ST_NO_CODE;
        r.code   = '0;
        r.bits   = '0;
        if (kind == 1'b0) begin
            // The first load after a closed set opens a new one.
            if (!set_open) begin
                set_open     = 1'b1;
                num_loaded   = 0;
                set_too_long = 1'b0;
                table_ok     = 1'b0;
            end
            // Lengths past the alphabet are dropped without a look.
            if (num_loaded < chca_pkg::ALPHABET_SIZE) begin
                if (len > chca_pkg::MAX_CODE_BITS)
                    set_too_long = 1'b1;
                else
                    sym_len[num_loaded] = len[chca_pkg::LEN_W-1:0];
                num_loaded++;
            end
            if (last !== 1'b1)
                return;
            build_codes();
            set_open = 1'b0;
            r.status = set_too_long ? chca_pkg::ST_TOO_LONG : chca_pkg::ST_OK;
            sets_built++;
            if (set_too_long)
                sets_rejected++;
        end else begin
            lookups++;
            if (table_ok && sym < num_loaded && sym_len[sym] != 0) begin
                r.status = chca_pkg::ST_OK;
                r.code   = sym_code[sym];
                r.bits   = sym_len[sym];
                lookup_hits++;
            end
        end
        owed_q.insert(owed_q.size(), r);
    endfunction

    // Called for every strobed response.
    function void check_reply(logic [chca_pkg::STAT_W-1:0] status,
                              logic [chca_pkg::CODE_W-1:0] code,
                              logic [chca_pkg::LEN_W-1:0] bits);
        t_huff_reply r;
        if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected response: status %0d code 0x%0h bits %0d",
                         status, code, bits);
            return;
        end
        r = owed_q.pop_front();
        if (status !== r.status || code !== r.code || bits !== r.bits) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"Mismatch: expected status %0d code 0x%0h bits %0d, ",
                          "got status %0d code 0x%0h bits %0d"},
                         r.status, r.code, r.bits, status, code, bits);
        end
    endfunction
endclass

module canonical_huffman_code_assign_tb;
    import chca_pkg::*;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;
    localparam int   CLK_HALF    = 5;
    // Directed items plus a short random run; the full-alphabet set that
    // follows adds about 530 more.
    localparam int   RANDOM_END  = 100;
    localparam int   SETTLE      = 8;
    localparam int   END_SETTLE  = 64;
    // Slowest correct run: roughly 700 requests, each after a random idle gap,
    // plus a build per set with two passes over its loaded lengths. The limit
    // leaves a wide margin above that.
    localparam int   CYCLE_LIMIT = 500000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_kind;
    logic [LEN_IN_W-1:0] i_code_len_in;
    logic                i_last_length;
    logic [SYM_W-1:0]    i_lookup_symbol;
    logic                o_strobe;
    logic [STAT_W-1:0]   o_status;
    logic [CODE_W-1:0]   o_code_value;
    logic [LEN_W-1:0]    o_code_bits;

    huffman_scoreboard sb;
    int cycle_count = 0;
    int sent_items  = 0;
    bit no_idle     = 1'b0;

    canonical_huffman_code_assign u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_code_len_in   (i_code_len_in),
        .i_last_length   (i_last_length),
        .i_lookup_symbol (i_lookup_symbol),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_code_value    (o_code_value),
        .o_code_bits     (o_code_bits)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses owed",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Inputs change only at rising edges, so the falling edge sees the values
    // that the next rising edge will act on.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_strobe !== 1'b0)
                sb.check_reply(o_status, o_code_value, o_code_bits);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(i_kind, i_code_len_in, i_last_length, i_lookup_symbol);
        end
    end

    // Holds one request on the ports until the block takes it. start stays
    // high on return, so a back-to-back request needs no extra edge.
    task automatic send_request(input logic kind, input logic [LEN_IN_W-1:0] len,
                                input logic last, input logic [SYM_W-1:0] sym);
        int gap;
        bit taken;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_kind          <= kind;
        i_code_len_in   <= len;
        i_last_length   <= last;
        i_lookup_symbol <= sym;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end
        sent_items++;
    endtask

    // Unused fields carry random bits.
    task automatic send_load(input int len, input bit last);
        send_request(KIND_LOAD, len[LEN_IN_W-1:0], last,
                     SYM_W'($urandom_range(0, ALPHABET_SIZE - 1)));
    endtask

    task automatic send_lookup(input int sym);
        send_request(KIND_LOOKUP, LEN_IN_W'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), sym[SYM_W-1:0]);
    endtask

    task automatic wait_for_replies(input int settle);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // A complete prefix code: split random leaves until there are n_used,
    // shuffle them into symbol order and sprinkle unused symbols between.
    function automatic t_len_list make_complete_code(int n_used, int zero_odds);
        t_len_list leaves;
        t_len_list lens;
        int idx;
        int v;
        int tmp;
        leaves = '{1, 1};
        while (leaves.size() < n_used) begin
            idx = $urandom_range(0, leaves.size() - 1);
            if (leaves[idx] < MAX_CODE_BITS) begin
                v = leaves[idx] + 1;
                leaves[idx] = v;
                leaves.insert(idx + 1, v);
            end
        end
        for (int i = leaves.size() - 1; i > 0; i--) begin
            idx = $urandom_range(0, i);
            tmp = leaves[i];
            leaves[i] = leaves[idx];
            leaves[idx] = tmp;
        end
        foreach (leaves[i]) begin
            if (zero_odds != 0 && $urandom_range(1, zero_odds) == 1)
                lens.insert(lens.size(), 0);
            lens.insert(lens.size(), leaves[i]);
        end
        return lens;
    endfunction

    function automatic t_len_list make_random_lengths(int n, int max_len);
        t_len_list lens;
        for (int i = 0; i < n; i++)
            lens.insert(lens.size(), $urandom_range(0, max_len));
        return lens;
    endfunction

    // Sends one set; with noise, stray lookups land while the set is open.
    task automatic send_set(input t_len_list lens, input bit noisy);
        foreach (lens[i]) begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_lookup($urandom_range(0, ALPHABET_SIZE - 1));
            send_load(lens[i], i == lens.size() - 1);
        end
    endtask

    // Lookups mostly inside the set just loaded, some anywhere.
    task automatic probe_table(input int span, input int count);
        int top;
        top = (span + 1 < ALPHABET_SIZE) ? span + 1 : ALPHABET_SIZE - 1;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_lookup($urandom_range(0, ALPHABET_SIZE - 1));
            else
                send_lookup($urandom_range(0, top));
        end
    endtask

    task automatic run_directed();
        // No table stands yet.
        send_lookup(0);
        // One length: symbol 0 becomes code 1 of length 1.
        send_load(7, 1'b1);
        send_lookup(0);
        send_lookup(1);
        // The textbook eight-symbol example, then a symbol past the set.
        send_load(3, 1'b0);
        send_load(3, 1'b0);
        send_load(3, 1'b0);
        send_load(3, 1'b0);
        send_load(3, 1'b0);
        send_load(2, 1'b0);
        send_load(4, 1'b0);
        send_load(4, 1'b1);
        send_lookup(0);
        send_lookup(5);
        send_lookup(7);
        send_lookup(8);
        // A length above the maximum fails the set and empties the table.
        send_load(MAX_CODE_BITS, 1'b0);
        send_load(31, 1'b1);
        send_lookup(0);
        // Unused symbols around two maximum-length codes.
        send_load(0, 1'b0);
        send_load(MAX_CODE_BITS, 1'b0);
        send_load(MAX_CODE_BITS, 1'b0);
        send_load(0, 1'b1);
        send_lookup(0);
        send_lookup(2);
    endtask

    task automatic run_random();
        t_len_list lens;
        int pick;
        int n;
        while (sent_items < RANDOM_END) begin
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 60)
                                                : $urandom_range(2, 16);
                lens = make_complete_code(n, $urandom_range(0, 5));
                send_set(lens, $urandom_range(0, 9) == 0);
                probe_table(lens.size(), $urandom_range(2, 10));
            end else if (pick < 70) begin
                // Any lengths, including over-full sets and one-length sets.
                lens = make_random_lengths($urandom_range(1, 20), MAX_CODE_BITS);
                send_set(lens, 1'b0);
                probe_table(lens.size(), $urandom_range(1, 6));
            end else if (pick < 80) begin
                lens = make_random_lengths($urandom_range(1, 12), MAX_CODE_BITS);
                lens[$urandom_range(0, lens.size() - 1)] = $urandom_range(MAX_CODE_BITS + 1, 31);
                send_set(lens, 1'b0);
                probe_table(lens.size(), $urandom_range(1, 4));
            end else if (pick < 90) begin
                probe_table(ALPHABET_SIZE, $urandom_range(1, 6));
            end else begin
                lens = make_complete_code($urandom_range(2, 10), 3);
                send_set(lens, 1'b1);
                probe_table(lens.size(), $urandom_range(1, 4));
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_replies(SETTLE);
        end
    endtask

    // A full alphabet, plus lengths past its end that must be ignored even
    // though they are over the maximum.
    task automatic run_full_alphabet();
        t_len_list lens;
        lens = make_random_lengths(ALPHABET_SIZE, 9);
        repeat (3) lens.insert(lens.size(), 31);
        no_idle = 1'b1;
        send_set(lens, 1'b0);
        no_idle = 1'b0;
        send_lookup(ALPHABET_SIZE - 1);
        send_lookup(0);
        probe_table(ALPHABET_SIZE, 12);
    endtask

    initial begin
        sb = new();
        start           <= 1'b0;
        i_kind          <= KIND_LOAD;
        i_code_len_in   <= '0;
        i_last_length   <= 1'b0;
        i_lookup_symbol <= '0;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        // Sender holds off until the block has answered everything.
        wait_for_replies(SETTLE);
        run_random();
        wait_for_replies(SETTLE);
        run_full_alphabet();
        wait_for_replies(END_SETTLE);

        if (sb.pending() != 0)
            $display("%0d expected responses never arrived", sb.pending());
        $display("Built %0d code sets (%0d rejected for an overlong length) from %0d requests.",
                 sb.sets_built, sb.sets_rejected, sent_items);
        $display("Answered %0d lookups, %0d with a code; %0d mismatches.",
                 sb.lookups, sb.lookup_hits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/chca_pkg.sv
design/chca_ram.sv
design/chca_dpath.sv
design/chca_ctrl.sv
design/canonical_huffman_code_assign.sv
tb/canonical_huffman_code_assign_tb.sv
